>>> hw/rtl/rsrg_pkg.sv
// Shared types, constants and the rank compare for the replacement-selection run generator.
`default_nettype none

package rsrg_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int KEY_W      = 32;
	localparam int RUN_W      = 16;
	localparam int CAP_W      = 11;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Input item kinds carried on s_tuser
	localparam logic OPC_PUSH  = 1'b0;
	localparam logic OPC_DRAIN = 1'b1;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic                    tag;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_REPLACE
	} cell_op_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		logic     cp;
		entry_t   new_entry;
	} cell_ctl_t;

	// True when entry a ranks no later than entry b; current-run entries come first.
	function automatic logic rank_le(entry_t a, entry_t b, logic cp);
		logic na;
		logic nb;
		na = (a.tag != cp);
		nb = (b.tag != cp);
		if (na != nb) begin
			return !na;
		end
		return (a.key <= b.key);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/replacement_selection_run_generator_top.sv
// Top level of the replacement-selection run generator.
// Input stream s_*: s_tuser[0] is the opcode (0 push, 1 drain), s_tdata carries key_in.
// Output stream m_*: one result per input item. m_tdata holds key_out then
// run_number; m_tuser holds out_valid then heap_empty.
// Configuration channel cfg_*: writes heap_capacity, always ready; write it
// only while no item is in flight.
// The heap is a chain of HEAP_DEPTH cells kept in rank order, every cell
// comparing its entry with the broadcast key and moving one place in the same
// cycle, so each item's result appears on m_* the cycle after the s_* transfer.
// An item is taken every cycle while the output register is empty or being
// drained.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until the result is transferred.
// Reset empties the heap, sets the run to zero and the capacity to 1024;
// the cells themselves are not cleared.
`default_nettype none

module replacement_selection_run_generator_top
	import rsrg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [31:0]      s_tdata,   // key_in[31:0]
	input  wire logic [0:0]       s_tuser,   // opcode[0]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [47:0]      m_tdata,   // key_out[31:0], run_number[47:32]
	output logic      [1:0]       m_tuser,   // out_valid[0], heap_empty[1]
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [RUN_W-1:0] run_q;
	logic             m_tvalid_q;
	logic signed [KEY_W-1:0] key_out_q;
	logic [RUN_W-1:0] run_out_q;
	logic             out_valid_q;
	logic             empty_q;

	logic [CNT_W-1:0] cap_eff;
	logic             in_fire;
	logic             opcode;
	logic signed [KEY_W-1:0] key_in;
	logic             has_entries;
	logic             full;
	logic             take;
	logic             advance;
	logic             cp_eff;
	entry_t           root;
	cell_ctl_t        ctl;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign opcode    = s_tuser[0];
	assign key_in    = s_tdata;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > HEAP_DEPTH) begin
			cap_eff = CNT_W'(HEAP_DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	assign has_entries = (count_q != '0);
	assign full        = (count_q >= cap_eff);
	assign take        = (opcode == OPC_PUSH) ? full : has_entries;
	// root from the next run means the current run is exhausted
	assign advance     = take && (root.tag != run_q[0]);
	assign cp_eff      = run_q[0] ^ advance;

	always_comb begin
		ctl.cp            = cp_eff;
		ctl.new_entry.key = key_in;
		ctl.new_entry.tag = cp_eff;
		ctl.op            = CELL_HOLD;
		if (in_fire) begin
			if (opcode == OPC_PUSH) begin
				if (full) begin
					ctl.op = CELL_REPLACE;
					if (key_in < root.key) begin
						ctl.new_entry.tag = !cp_eff;
					end
				end else begin
					ctl.op = CELL_INSERT;
				end
			end else if (has_entries) begin
				ctl.op = CELL_POP;
			end
		end
	end

	rsrg_chain u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.count (count_q),
		.root  (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAP_RESET;
			count_q    <= '0;
			run_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (in_fire) begin
				m_tvalid_q <= 1'b1;
				run_q      <= run_q + RUN_W'(advance);
				if (ctl.op == CELL_INSERT) begin
					count_q <= count_q + CNT_W'(1);
				end else if (ctl.op == CELL_POP) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_valid_q <= take;
			key_out_q   <= take ? root.key : '0;
			run_out_q   <= run_q + RUN_W'(advance);
			empty_q     <= (opcode == OPC_DRAIN) && !has_entries;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {run_out_q, key_out_q};
	assign m_tuser  = {empty_q, out_valid_q};

endmodule

`default_nettype wire

>>> hw/rtl/rsrg_cell.sv
// One cell of the sorted chain: holds one heap entry and trades it with its neighbors.
`default_nettype none

module rsrg_cell
	import rsrg_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      head,
	input  wire logic      occupied,
	input  wire logic      lt_left,
	input  wire logic      lt_right,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	output entry_t         entry,
	output logic           lt
);

	entry_t entry_q;
	entry_t entry_d;

	assign entry = entry_q;
	assign lt    = occupied && rank_le(entry_q, ctl.new_entry, ctl.cp);

	always_comb begin
		entry_d = entry_q;
		unique case (ctl.op)
			CELL_HOLD: begin
				entry_d = entry_q;
			end
			CELL_INSERT: begin
				// keep when ranking no later than the new key, else take it or shift right
				if (lt) begin
					entry_d = entry_q;
				end else if (lt_left) begin
					entry_d = ctl.new_entry;
				end else begin
					entry_d = left_entry;
				end
			end
			CELL_POP: begin
				entry_d = right_entry;
			end
			CELL_REPLACE: begin
				// root leaves; the new key drops into its slot while the prefix shifts left
				if (lt_right) begin
					entry_d = right_entry;
				end else if (lt || head) begin
					entry_d = ctl.new_entry;
				end else begin
					entry_d = entry_q;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

>>> hw/rtl/rsrg_chain.sv
// Row of cells kept in rank order; cell 0 holds the root.
`default_nettype none

module rsrg_chain
	import rsrg_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [CNT_W-1:0] count,
	output entry_t                root
);

	entry_t entries [HEAP_DEPTH];
	logic   lts     [HEAP_DEPTH];

	assign root = entries[0];

	for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
		logic   occupied;
		logic   lt_left;
		logic   lt_right;
		entry_t left_entry;
		entry_t right_entry;

		assign occupied = (CNT_W'(i) < count);

		if (i == 0) begin : g_first
			assign lt_left    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign lt_left    = lts[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == HEAP_DEPTH - 1) begin : g_last
			assign lt_right    = 1'b0;
			assign right_entry = '0;
		end else begin : g_body
			assign lt_right    = lts[i+1];
			assign right_entry = entries[i+1];
		end

		rsrg_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.head        ((i == 0) ? 1'b1 : 1'b0),
			.occupied    (occupied),
			.lt_left     (lt_left),
			.lt_right    (lt_right),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.lt          (lts[i])
		);
	end

endmodule

`default_nettype wire
